// File: src/typed_column_comparator_defines.svh
// Assertion macros shared by the comparator RTL.
`ifndef TYPED_COLUMN_COMPARATOR_DEFINES_SVH
`define TYPED_COLUMN_COMPARATOR_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define TCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/tcc_pkg.sv
package tcc_pkg;

	typedef enum logic [2:0] {
		OP_EQ = 3'd0,
		OP_NE = 3'd1,
		OP_GT = 3'd2,
		OP_GE = 3'd3,
		OP_LT = 3'd4,
		OP_LE = 3'd5
	} cmp_op_t;

	typedef enum logic [3:0] {
		TY_BOOL = 4'd0,
		TY_I8 = 4'd1,
		TY_I16 = 4'd2,
		TY_I32 = 4'd3,
		TY_I64 = 4'd4,
		TY_U8 = 4'd5,
		TY_U16 = 4'd6,
		TY_U32 = 4'd7,
		TY_U64 = 4'd8,
		TY_F32 = 4'd9,
		TY_F64 = 4'd10,
		TY_DATE = 4'd11,
		TY_TIME = 4'd12,
		TY_DATETIME = 4'd13,
		TY_TIMESTAMP = 4'd14,
		TY_INVALID = 4'd15
	} elem_type_t;

	localparam logic [1:0] REG_OP = 2'd0;
	localparam logic [1:0] REG_TYPE = 2'd1;
	localparam logic [1:0] REG_SIDE = 2'd2;
	localparam logic [1:0] REG_SCALAR = 2'd3;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned CFG_IDX_W = 2;

	typedef struct packed {
		logic [WORD_W-1:0] left_value;
		logic [WORD_W-1:0] right_value;
		logic is_null;
		logic last_element;
	} in_item_t;

	typedef struct packed {
		logic match;
		logic written;
		logic type_error;
		logic last_result;
	} out_item_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic unord;
		logic bad;
	} order_t;

endpackage

// File: src/tcc_stream_if.sv
interface tcc_in_if;
	logic valid;
	logic ready;
	tcc_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcc_out_if;
	logic valid;
	logic ready;
	tcc_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/typed_column_comparator.sv
// Channel  | Dir | Payload
// in_ch    | in  | left_value, right_value, is_null, last_element
// out_ch   | out | match, written, type_error, last_result
// cfg      | in  | cfg_index, cfg_data (written when cfg_we is high)
// One item per cycle while the output is not stalled.
// Items pass an input register and a result register; the order logic sits between.
// Reset clears valid flags and configuration registers to zero.
// A stalled output holds its stages; ready propagates back through each stage.
`include "typed_column_comparator_defines.svh"

module typed_column_comparator (
	input logic clk,
	input logic arst_n,
	tcc_in_if.sink in_ch,
	tcc_out_if.source out_ch,
	input logic cfg_we,
	input logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tcc_pkg::WORD_W-1:0] cfg_data
);
	logic [2:0] op_q;
	logic [3:0] type_q;
	logic [1:0] side_q;
	logic [63:0] scalar_q;
	logic valid_s1;
	tcc_pkg::in_item_t item_s1;
	logic valid_s2;
	tcc_pkg::out_item_t res_s2;
	logic adv_s2;
	logic adv_s1;
	logic [63:0] opx;
	logic [63:0] opy;
	tcc_pkg::order_t ord;
	tcc_pkg::out_item_t res;
	logic op_bad;
	logic hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			type_q <= '0;
			side_q <= '0;
			scalar_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcc_pkg::REG_OP: op_q <= cfg_data[2:0];
				tcc_pkg::REG_TYPE: type_q <= cfg_data[3:0];
				tcc_pkg::REG_SIDE: side_q <= cfg_data[1:0];
				tcc_pkg::REG_SCALAR: scalar_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2 = !valid_s2 || out_ch.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
	end

	assign opx = side_q[0] ? scalar_q : item_s1.left_value;
	assign opy = (!side_q[0] && side_q[1]) ? scalar_q : item_s1.right_value;

	tcc_order u_order (
		.elem_type(type_q),
		.x(opx),
		.y(opy),
		.ord(ord)
	);

	always_comb begin
		op_bad = 1'b0;
		hit = 1'b0;
		unique case (tcc_pkg::cmp_op_t'(op_q))
			tcc_pkg::OP_EQ: hit = ord.eq;
			tcc_pkg::OP_NE: hit = !ord.eq;
			tcc_pkg::OP_GT: hit = ord.gt;
			tcc_pkg::OP_GE: hit = ord.gt || ord.eq;
			tcc_pkg::OP_LT: hit = ord.lt;
			tcc_pkg::OP_LE: hit = ord.lt || ord.eq;
			default: op_bad = 1'b1;
		endcase
		res.type_error = op_bad || ord.bad;
		res.written = !res.type_error && !item_s1.is_null;
		res.match = res.written && hit;
		res.last_result = item_s1.last_element;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data = res_s2;

	`TCC_ASSERT_SAME(a_match_written, clk, arst_n, valid_s2, !res_s2.match || res_s2.written)
	`TCC_ASSERT_SAME(a_err_no_write, clk, arst_n, valid_s2, !(res_s2.type_error && res_s2.written))
	`TCC_ASSERT_NEXT(a_hold_stall, clk, arst_n, valid_s2 && !out_ch.ready,
		valid_s2 && $stable(res_s2))
endmodule

// File: src/tcc_order.sv
module tcc_order (
	input logic [3:0] elem_type,
	input logic [63:0] x,
	input logic [63:0] y,
	output tcc_pkg::order_t ord
);
	logic [63:0] xk;
	logic [63:0] yk;
	logic is_float;
	logic ty_bad;
	logic f_nan;
	logic f_zero;
	logic xs;
	logic ys;
	logic [62:0] xm;
	logic [62:0] ym;
	logic mag_lt;
	logic mag_eq;
	logic int_lt;
	logic int_eq;
	logic f_lt;
	logic f_eq;

	always_comb begin
		xk = '0;
		yk = '0;
		is_float = 1'b0;
		ty_bad = 1'b0;
		xs = 1'b0;
		ys = 1'b0;
		xm = '0;
		ym = '0;
		f_nan = 1'b0;
		unique case (tcc_pkg::elem_type_t'(elem_type))
			tcc_pkg::TY_BOOL: begin
				xk = {63'd0, |x[7:0]};
				yk = {63'd0, |y[7:0]};
			end
			tcc_pkg::TY_I8: begin
				xk = {56'd0, ~x[7], x[6:0]};
				yk = {56'd0, ~y[7], y[6:0]};
			end
			tcc_pkg::TY_I16: begin
				xk = {48'd0, ~x[15], x[14:0]};
				yk = {48'd0, ~y[15], y[14:0]};
			end
			tcc_pkg::TY_I32, tcc_pkg::TY_DATE: begin
				xk = {32'd0, ~x[31], x[30:0]};
				yk = {32'd0, ~y[31], y[30:0]};
			end
			tcc_pkg::TY_I64, tcc_pkg::TY_TIME, tcc_pkg::TY_DATETIME,
			tcc_pkg::TY_TIMESTAMP: begin
				xk = {~x[63], x[62:0]};
				yk = {~y[63], y[62:0]};
			end
			tcc_pkg::TY_U8: begin
				xk = {56'd0, x[7:0]};
				yk = {56'd0, y[7:0]};
			end
			tcc_pkg::TY_U16: begin
				xk = {48'd0, x[15:0]};
				yk = {48'd0, y[15:0]};
			end
			tcc_pkg::TY_U32: begin
				xk = {32'd0, x[31:0]};
				yk = {32'd0, y[31:0]};
			end
			tcc_pkg::TY_U64: begin
				xk = x;
				yk = y;
			end
			tcc_pkg::TY_F32: begin
				is_float = 1'b1;
				xs = x[31];
				ys = y[31];
				xm = {32'd0, x[30:0]};
				ym = {32'd0, y[30:0]};
				f_nan = (&x[30:23] && |x[22:0]) || (&y[30:23] && |y[22:0]);
			end
			tcc_pkg::TY_F64: begin
				is_float = 1'b1;
				xs = x[63];
				ys = y[63];
				xm = x[62:0];
				ym = y[62:0];
				f_nan = (&x[62:52] && |x[51:0]) || (&y[62:52] && |y[51:0]);
			end
			default: ty_bad = 1'b1;
		endcase
	end

	assign int_lt = xk < yk;
	assign int_eq = xk == yk;
	assign mag_lt = xm < ym;
	assign mag_eq = xm == ym;
	assign f_zero = (xm == '0) && (ym == '0);

	always_comb begin
		if (f_zero) begin
			f_eq = 1'b1;
			f_lt = 1'b0;
		end else if (xs != ys) begin
			f_eq = 1'b0;
			f_lt = xs;
		end else begin
			f_eq = mag_eq;
			f_lt = xs ? (!mag_lt && !mag_eq) : mag_lt;
		end
	end

	always_comb begin
		ord.bad = ty_bad;
		if (is_float) begin
			ord.unord = f_nan;
			ord.eq = !f_nan && f_eq;
			ord.lt = !f_nan && f_lt;
			ord.gt = !f_nan && !f_lt && !f_eq;
		end else begin
			ord.unord = 1'b0;
			ord.eq = int_eq;
			ord.lt = int_lt;
			ord.gt = !int_lt && !int_eq;
		end
	end
endmodule

// File: tb/typed_column_comparator_checker.sv
`timescale 1ns / 1ps

module typed_column_comparator_checker (
	input logic clk,
	input logic arst_n,
	tcc_in_if in_ch,
	tcc_out_if out_ch,
	input logic cfg_we,
	input logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tcc_pkg::WORD_W-1:0] cfg_data,
	output int errors,
	output int pending,
	output int results_seen,
	output int results_written
);
	typedef enum logic [2:0] {
		ORD_LT,
		ORD_EQ,
		ORD_GT,
		ORD_UN,
		ORD_BAD
	} order_kind_t;

	logic [2:0] op_q;
	logic [3:0] type_q;
	logic [1:0] side_q;
	logic [63:0] scalar_q;
	tcc_pkg::out_item_t verdicts[$];

	function automatic order_kind_t int_order(logic [63:0] a, logic [63:0] b, int w, bit sgn);
		logic [63:0] m;
		logic [63:0] bias;
		logic [63:0] ka;
		logic [63:0] kb;
		m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		bias = sgn ? (64'd1 << (w - 1)) : 64'd0;
		ka = (a & m) ^ bias;
		kb = (b & m) ^ bias;
		if (ka < kb) return ORD_LT;
		if (ka > kb) return ORD_GT;
		return ORD_EQ;
	endfunction

	function automatic order_kind_t float_order(logic [63:0] a, logic [63:0] b, bit dbl);
		logic sa;
		logic sb;
		logic [62:0] ma;
		logic [62:0] mb;
		logic nan_a;
		logic nan_b;
		if (dbl) begin
			sa = a[63];
			sb = b[63];
			ma = a[62:0];
			mb = b[62:0];
			nan_a = (&a[62:52]) && (|a[51:0]);
			nan_b = (&b[62:52]) && (|b[51:0]);
		end else begin
			sa = a[31];
			sb = b[31];
			ma = {32'd0, a[30:0]};
			mb = {32'd0, b[30:0]};
			nan_a = (&a[30:23]) && (|a[22:0]);
			nan_b = (&b[30:23]) && (|b[22:0]);
		end
		if (nan_a || nan_b) return ORD_UN;
		if (ma == 0 && mb == 0) return ORD_EQ;
		if (sa != sb) return sa ? ORD_LT : ORD_GT;
		if (ma == mb) return ORD_EQ;
		return ((ma < mb) ^ sa) ? ORD_LT : ORD_GT;
	endfunction

	function automatic order_kind_t typed_order(logic [63:0] a, logic [63:0] b);
		case (tcc_pkg::elem_type_t'(type_q))
			tcc_pkg::TY_BOOL: return int_order({63'd0, |a[7:0]}, {63'd0, |b[7:0]}, 64, 0);
			tcc_pkg::TY_I8: return int_order(a, b, 8, 1);
			tcc_pkg::TY_I16: return int_order(a, b, 16, 1);
			tcc_pkg::TY_I32, tcc_pkg::TY_DATE: return int_order(a, b, 32, 1);
			tcc_pkg::TY_I64, tcc_pkg::TY_TIME, tcc_pkg::TY_DATETIME,
			tcc_pkg::TY_TIMESTAMP: return int_order(a, b, 64, 1);
			tcc_pkg::TY_U8: return int_order(a, b, 8, 0);
			tcc_pkg::TY_U16: return int_order(a, b, 16, 0);
			tcc_pkg::TY_U32: return int_order(a, b, 32, 0);
			tcc_pkg::TY_U64: return int_order(a, b, 64, 0);
			tcc_pkg::TY_F32: return float_order(a, b, 0);
			tcc_pkg::TY_F64: return float_order(a, b, 1);
			default: return ORD_BAD;
		endcase
	endfunction

	function automatic tcc_pkg::out_item_t filter_verdict(tcc_pkg::in_item_t it);
		tcc_pkg::out_item_t r;
		logic [63:0] a;
		logic [63:0] b;
		order_kind_t ord;
		a = it.left_value;
		b = it.right_value;
		if (side_q[0]) a = scalar_q;
		else if (side_q[1]) b = scalar_q;
		ord = typed_order(a, b);
		r = '0;
		r.last_result = it.last_element;
		if (ord == ORD_BAD || op_q > tcc_pkg::OP_LE) begin
			r.type_error = 1'b1;
		end else if (!it.is_null) begin
			r.written = 1'b1;
			case (tcc_pkg::cmp_op_t'(op_q))
				tcc_pkg::OP_EQ: r.match = (ord == ORD_EQ);
				tcc_pkg::OP_NE: r.match = (ord != ORD_EQ);
				tcc_pkg::OP_GT: r.match = (ord == ORD_GT);
				tcc_pkg::OP_GE: r.match = (ord == ORD_GT || ord == ORD_EQ);
				tcc_pkg::OP_LT: r.match = (ord == ORD_LT);
				default: r.match = (ord == ORD_LT || ord == ORD_EQ);
			endcase
		end
		return r;
	endfunction

	task automatic field_check(string name, logic e, logic g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, e, g);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tcc_pkg::out_item_t e;
		tcc_pkg::out_item_t g;
		if (!arst_n) begin
			op_q <= '0;
			type_q <= '0;
			side_q <= '0;
			scalar_q <= '0;
			errors = 0;
			results_seen <= 0;
			results_written <= 0;
			verdicts.delete();
			pending = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) verdicts.push_back(filter_verdict(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				g = out_ch.data;
				results_seen <= results_seen + 1;
				if (g.written) results_written <= results_written + 1;
				if (verdicts.size() == 0) begin
					$display("%0t: result with nothing expected, actual %b", $time, g);
					errors++;
				end else begin
					e = verdicts.pop_front();
					field_check("match", e.match, g.match);
					field_check("written", e.written, g.written);
					field_check("type_error", e.type_error, g.type_error);
					field_check("last_result", e.last_result, g.last_result);
				end
			end
			pending = verdicts.size();
			if (cfg_we) begin
				case (cfg_index)
					tcc_pkg::REG_OP: op_q <= cfg_data[2:0];
					tcc_pkg::REG_TYPE: type_q <= cfg_data[3:0];
					tcc_pkg::REG_SIDE: side_q <= cfg_data[1:0];
					default: scalar_q <= cfg_data;
				endcase
			end
		end
	end
endmodule

// File: tb/typed_column_comparator_test.sv
`timescale 1ns / 1ps

module typed_column_comparator_test;
	localparam logic [2:0] OP_BAD_LO = 3'd6;
	localparam logic [2:0] OP_BAD_HI = 3'd7;
	localparam logic [1:0] SIDE_BOTH = 2'd0;
	localparam logic [1:0] SIDE_LEFT = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;
	localparam logic [1:0] SIDE_FLAGS = 2'd3;
	localparam logic [63:0] F64_NAN = 64'h7FF8_0000_0000_0001;
	localparam logic [63:0] F64_NEG_ZERO = 64'h8000_0000_0000_0000;
	localparam logic [63:0] F32_NAN = 64'h0000_0000_7FC0_0001;
	localparam logic [63:0] F32_NEG_ONE = 64'h0000_0000_BF80_0000;
	localparam int CYCLE_LIMIT = 300000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tcc_pkg::WORD_W-1:0] cfg_data;
	int errors;
	int pending;
	int results_seen;
	int results_written;
	int items_sent;
	int cycles;
	bit calm;

	tcc_in_if in_ch ();
	tcc_out_if out_ch ();

	typed_column_comparator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typed_column_comparator_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.results_seen(results_seen),
		.results_written(results_written)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else out_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("typed_column_comparator_test failed");
			$finish;
		end
	end

	task automatic send_pair(logic [63:0] l, logic [63:0] r, bit nul, bit last);
		tcc_pkg::in_item_t it;
		it.left_value = l;
		it.right_value = r;
		it.is_null = nul;
		it.last_element = last;
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		items_sent++;
	endtask

	// Lets every result drain, then writes all four registers back to back.
	task automatic configure(logic [2:0] op, logic [3:0] ty, logic [1:0] side, logic [63:0] sc);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tcc_pkg::REG_OP;
		cfg_data <= 64'(op);
		@(posedge clk);
		cfg_index <= tcc_pkg::REG_TYPE;
		cfg_data <= 64'(ty);
		@(posedge clk);
		cfg_index <= tcc_pkg::REG_SIDE;
		cfg_data <= 64'(side);
		@(posedge clk);
		cfg_index <= tcc_pkg::REG_SCALAR;
		cfg_data <= sc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 64'(($urandom_range(0, 3)));
			1: return '1;
			2: return F64_NAN;
			3: return F32_NAN;
			4: return F64_NEG_ZERO;
			5: return {32'd0, $urandom_range(0, 1) ? 32'h7F80_0000 : 32'hFF80_0000};
			6: return 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic [63:0] l;
		logic [63:0] r;
		logic [2:0] op;
		int n;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		items_sent = 0;
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: equality on bools, where only the low byte counts.
		send_pair(64'h100, 64'h0, 0, 0);
		send_pair(64'h1, 64'hFF00_0000_0000_0080, 0, 0);
		send_pair(64'h1, 64'h0, 1, 1);
		configure(tcc_pkg::OP_GT, tcc_pkg::TY_I8, SIDE_BOTH, '0);
		send_pair(64'h80, 64'h7F, 0, 0);
		send_pair(64'hFFFF_FF7F, 64'h80, 0, 1);
		configure(tcc_pkg::OP_LE, tcc_pkg::TY_U64, SIDE_BOTH, '0);
		send_pair('1, 64'h0, 0, 0);
		send_pair(64'h0, '1, 0, 1);
		configure(tcc_pkg::OP_NE, tcc_pkg::TY_F64, SIDE_BOTH, '0);
		send_pair(F64_NAN, F64_NAN, 0, 0);
		configure(tcc_pkg::OP_EQ, tcc_pkg::TY_F64, SIDE_RIGHT, F64_NEG_ZERO);
		send_pair(F64_NAN, 64'h0, 0, 0);
		send_pair(64'h0, 64'h5, 0, 1);
		configure(tcc_pkg::OP_LT, tcc_pkg::TY_F32, SIDE_LEFT, F32_NEG_ONE);
		send_pair(F32_NAN, F32_NAN, 0, 0);
		send_pair(64'h0, 64'h0, 0, 1);
		configure(tcc_pkg::OP_GE, tcc_pkg::TY_INVALID, SIDE_BOTH, '0);
		send_pair(64'h1, 64'h1, 0, 0);
		send_pair(64'h1, 64'h1, 1, 1);
		configure(OP_BAD_LO, tcc_pkg::TY_I32, SIDE_BOTH, '0);
		send_pair(64'h1, 64'h2, 0, 0);
		configure(OP_BAD_HI, tcc_pkg::TY_DATE, SIDE_FLAGS, 64'h8000_0000);
		send_pair(64'h1, 64'h2, 0, 1);
		configure(tcc_pkg::OP_GE, tcc_pkg::TY_TIMESTAMP, SIDE_FLAGS, 64'h8000_0000_0000_0000);
		send_pair('1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1);

		for (int phase = 0; phase < 33; phase++) begin
			op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
			configure(op, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), pick_word());
			calm = (phase == 16);
			n = $urandom_range(30, 70);
			for (int k = 0; k < n; k++) begin
				l = pick_word();
				r = ($urandom_range(0, 3) == 0) ? l : pick_word();
				if ($urandom_range(0, 4) == 0) r = l ^ (64'd1 << $urandom_range(0, 63));
				send_pair(l, r, $urandom_range(0, 7) == 0, k == n - 1);
			end
		end

		in_ch.valid <= 1'b0;
		calm = 0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d element pairs over all operators, element types and scalar sides;",
			items_sent);
		$display("%0d results checked, %0d of them written, %0d mismatches.",
			results_seen, results_written, errors);
		if (errors == 0 && pending == 0) begin
			$display("typed_column_comparator_test passed");
		end else begin
			$display("typed_column_comparator_test failed");
		end
		$finish;
	end
endmodule
